// ===== design/ppm_pkg.sv =====
// Shared types, widths and helpers for the perspective point mapper.
// Used by ppm_front, ppm_divider and perspective_point_mapper_top.
package ppm_pkg;

   localparam int COORD_W  = 32;
   localparam int PROD_W   = 2 * COORD_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int NUM_SH   = 22;
   localparam int XY_SH    = 24;
   localparam int W_SH     = 22;
   localparam int REM_W    = SUM_W + NUM_SH;
   localparam int Q_W      = COORD_W + 1;
   localparam int CMP_W    = SUM_W + Q_W - 1;
   localparam int BIG_SH   = Q_W - NUM_SH;
   localparam int BIG_W    = SUM_W + BIG_SH;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [Q_W-1:0]     NEG_LIM = {2'b01, {(Q_W-2){1'b0}}};
   localparam logic [Q_W-1:0]     POS_LIM = {2'b00, {(Q_W-2){1'b1}}};

   localparam logic [CSR_W-1:0] RST_X_TERMS = 64'h0100_0000_0000_0000;
   localparam logic [CSR_W-1:0] RST_Y_TERMS = 64'h0000_0000_0100_0000;
   localparam logic [CSR_W-1:0] RST_OFFSETS = 64'h0;
   localparam logic [CSR_W-1:0] RST_PERSP   = 64'h0;
   localparam logic [COORD_W-1:0] RST_W_CONST = 32'h0100_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_TERMS = 3'd0,
      CSR_Y_TERMS = 3'd1,
      CSR_OFFSETS = 3'd2,
      CSR_PERSP   = 3'd3,
      CSR_W_CONST = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic                      w_zero;
      logic                      overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a;
      logic signed [COORD_W-1:0] b;
      logic signed [COORD_W-1:0] c;
      logic signed [COORD_W-1:0] d;
      logic signed [COORD_W-1:0] e;
      logic signed [COORD_W-1:0] f;
      logic signed [COORD_W-1:0] g;
      logic signed [COORD_W-1:0] h;
      logic signed [COORD_W-1:0] i;
   } coef_type;

   typedef struct packed {
      logic             valid;
      logic             w_zero;
      logic             neg_x;
      logic             neg_y;
      logic             big_x;
      logic             big_y;
      logic [SUM_W-1:0] den;
      logic [REM_W-1:0] rem_x;
      logic [REM_W-1:0] rem_y;
      logic [Q_W-1:0]   q_x;
      logic [Q_W-1:0]   q_y;
   } div_stage_type;

   typedef struct packed {
      logic [COORD_W-1:0] value;
      logic               ovf;
   } sat_type;

   // Apply sign and clamp a magnitude quotient to signed Q16.16.
   function automatic sat_type sat_quotient(logic [Q_W-1:0] q, logic neg, logic big);
      sat_type r;
      r.ovf   = 1'b0;
      r.value = q[COORD_W-1:0];
      if (neg) begin
         if (big || (q > NEG_LIM)) begin
            r.ovf   = 1'b1;
            r.value = NEG_MIN;
         end else begin
            r.value = COORD_W'(~q + Q_W'(1));
         end
      end else if (big || (q > POS_LIM)) begin
         r.ovf   = 1'b1;
         r.value = POS_MAX;
      end
      return r;
   endfunction

endpackage

// ===== design/perspective_point_mapper_top.sv =====
// Top level of the perspective point mapper: config registers, pipeline
// control and output stage. Depends on ppm_pkg, ppm_front, ppm_divider.
//
// Maps each input word (in_x, in_y, signed Q16.16) through the 3x3
// projective matrix held in five config registers, written over the csr_
// port (index 0..4, others ignored); the user must write them only while
// no points are in flight, which the block itself does not enforce.
// Each result word carries X/W and Y/W in signed Q16.16, truncated toward
// zero and clamped, with an overflow flag, or zeros and w_zero when W = 0.
// The pipeline has 38 register stages: 4 front stages (multiply, sum,
// magnitude, divider setup), 33 divider stages of one quotient bit each,
// and the output register. Throughput is one word per cycle, set by the
// one-bit-per-stage divider, except while rsp_stall freezes the pipeline.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity matrix.
module perspective_point_mapper_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ppm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ppm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [ppm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppm_pkg::CSR_W-1:0]          csr_wdata
);

   logic [ppm_pkg::CSR_W-1:0]   x_terms_ff, y_terms_ff, offsets_ff, persp_ff;
   logic [ppm_pkg::COORD_W-1:0] w_const_ff;
   ppm_pkg::coef_type           coef;

   logic                   adv;
   ppm_pkg::div_stage_type front_out, div_out;
   ppm_pkg::sat_type       sat_x, sat_y;
   logic                   rsp_valid_ff;
   ppm_pkg::rsp_type       rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_terms_ff <= ppm_pkg::RST_X_TERMS;
         y_terms_ff <= ppm_pkg::RST_Y_TERMS;
         offsets_ff <= ppm_pkg::RST_OFFSETS;
         persp_ff   <= ppm_pkg::RST_PERSP;
         w_const_ff <= ppm_pkg::RST_W_CONST;
      end else if (csr_we) begin
         unique case (ppm_pkg::csr_index_type'(csr_index))
            ppm_pkg::CSR_X_TERMS: x_terms_ff <= csr_wdata;
            ppm_pkg::CSR_Y_TERMS: y_terms_ff <= csr_wdata;
            ppm_pkg::CSR_OFFSETS: offsets_ff <= csr_wdata;
            ppm_pkg::CSR_PERSP:   persp_ff   <= csr_wdata;
            ppm_pkg::CSR_W_CONST: w_const_ff <= csr_wdata[ppm_pkg::COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.a = signed'(x_terms_ff[2*ppm_pkg::COORD_W-1:ppm_pkg::COORD_W]);
      coef.b = signed'(x_terms_ff[ppm_pkg::COORD_W-1:0]);
      coef.d = signed'(y_terms_ff[2*ppm_pkg::COORD_W-1:ppm_pkg::COORD_W]);
      coef.e = signed'(y_terms_ff[ppm_pkg::COORD_W-1:0]);
      coef.c = signed'(offsets_ff[2*ppm_pkg::COORD_W-1:ppm_pkg::COORD_W]);
      coef.f = signed'(offsets_ff[ppm_pkg::COORD_W-1:0]);
      coef.g = signed'(persp_ff[2*ppm_pkg::COORD_W-1:ppm_pkg::COORD_W]);
      coef.h = signed'(persp_ff[ppm_pkg::COORD_W-1:0]);
      coef.i = signed'(w_const_ff);
   end

   // pipeline moves whenever the output register is empty or being taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   ppm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .coef      (coef),
      .div_out   (front_out)
   );

   ppm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .div_in  (front_out),
      .div_out (div_out)
   );

   always_comb begin
      sat_x = ppm_pkg::sat_quotient(div_out.q_x, div_out.neg_x, div_out.big_x);
      sat_y = ppm_pkg::sat_quotient(div_out.q_y, div_out.neg_y, div_out.big_y);
      if (div_out.w_zero) begin
         rsp_in.out_x    = '0;
         rsp_in.out_y    = '0;
         rsp_in.w_zero   = 1'b1;
         rsp_in.overflow = 1'b0;
      end else begin
         rsp_in.out_x    = signed'(sat_x.value);
         rsp_in.out_y    = signed'(sat_y.value);
         rsp_in.w_zero   = 1'b0;
         rsp_in.overflow = sat_x.ovf | sat_y.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/ppm_front.sv =====
// Front end of the point mapper: products, exact sums, magnitudes and
// divider setup over four register stages. Depends on ppm_pkg.
module ppm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   req_valid,
   input  ppm_pkg::req_type       req_data,
   input  ppm_pkg::coef_type      coef,
   output ppm_pkg::div_stage_type div_out
);

   // stage 1: products
   logic                               v1_ff;
   logic signed [ppm_pkg::PROD_W-1:0]  pa_ff, pb_ff, pd_ff, pe_ff, pg_ff, ph_ff;
   logic signed [ppm_pkg::COORD_W-1:0] c_ff, f_ff, i_ff;
   logic signed [ppm_pkg::PROD_W-1:0]  pa_in, pb_in, pd_in, pe_in, pg_in, ph_in;

   // stage 2: sums
   logic                              v2_ff;
   logic signed [ppm_pkg::SUM_W-1:0]  sx_ff, sy_ff, sw_ff;
   logic signed [ppm_pkg::SUM_W-1:0]  sx_in, sy_in, sw_in;

   // stage 3: magnitudes
   logic                       v3_ff, wz_ff, nx_ff, ny_ff;
   logic [ppm_pkg::SUM_W-1:0]  mx_ff, my_ff, mw_ff;
   logic                       wz_in, nx_in, ny_in;
   logic [ppm_pkg::SUM_W-1:0]  mx_in, my_in, mw_in;

   // stage 4: divider setup
   ppm_pkg::div_stage_type     div_ff, div_in;
   logic [ppm_pkg::BIG_W-1:0]  wlim;

   always_comb begin
      pa_in = ppm_pkg::PROD_W'(coef.a) * ppm_pkg::PROD_W'(req_data.in_x);
      pb_in = ppm_pkg::PROD_W'(coef.b) * ppm_pkg::PROD_W'(req_data.in_y);
      pd_in = ppm_pkg::PROD_W'(coef.d) * ppm_pkg::PROD_W'(req_data.in_x);
      pe_in = ppm_pkg::PROD_W'(coef.e) * ppm_pkg::PROD_W'(req_data.in_y);
      pg_in = ppm_pkg::PROD_W'(coef.g) * ppm_pkg::PROD_W'(req_data.in_x);
      ph_in = ppm_pkg::PROD_W'(coef.h) * ppm_pkg::PROD_W'(req_data.in_y);
   end

   always_comb begin
      sx_in = ppm_pkg::SUM_W'(pa_ff) + ppm_pkg::SUM_W'(pb_ff)
            + (ppm_pkg::SUM_W'(c_ff) <<< ppm_pkg::XY_SH);
      sy_in = ppm_pkg::SUM_W'(pd_ff) + ppm_pkg::SUM_W'(pe_ff)
            + (ppm_pkg::SUM_W'(f_ff) <<< ppm_pkg::XY_SH);
      sw_in = ppm_pkg::SUM_W'(pg_ff) + ppm_pkg::SUM_W'(ph_ff)
            + (ppm_pkg::SUM_W'(i_ff) <<< ppm_pkg::W_SH);
   end

   always_comb begin
      wz_in = (sw_ff == '0);
      nx_in = sx_ff[ppm_pkg::SUM_W-1] ^ sw_ff[ppm_pkg::SUM_W-1];
      ny_in = sy_ff[ppm_pkg::SUM_W-1] ^ sw_ff[ppm_pkg::SUM_W-1];
      mx_in = sx_ff[ppm_pkg::SUM_W-1] ? unsigned'(-sx_ff) : unsigned'(sx_ff);
      my_in = sy_ff[ppm_pkg::SUM_W-1] ? unsigned'(-sy_ff) : unsigned'(sy_ff);
      mw_in = sw_ff[ppm_pkg::SUM_W-1] ? unsigned'(-sw_ff) : unsigned'(sw_ff);
   end

   // quotient reaches 2^Q_W when |num| >= |W| << (Q_W - NUM_SH)
   always_comb begin
      wlim          = ppm_pkg::BIG_W'(mw_ff) << ppm_pkg::BIG_SH;
      div_in.valid  = v3_ff;
      div_in.w_zero = wz_ff;
      div_in.neg_x  = nx_ff;
      div_in.neg_y  = ny_ff;
      div_in.big_x  = ppm_pkg::BIG_W'(mx_ff) >= wlim;
      div_in.big_y  = ppm_pkg::BIG_W'(my_ff) >= wlim;
      div_in.den    = mw_ff;
      div_in.rem_x  = ppm_pkg::REM_W'(mx_ff) << ppm_pkg::NUM_SH;
      div_in.rem_y  = ppm_pkg::REM_W'(my_ff) << ppm_pkg::NUM_SH;
      div_in.q_x    = '0;
      div_in.q_y    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         div_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         div_ff <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pd_ff <= pd_in;
         pe_ff <= pe_in;
         pg_ff <= pg_in;
         ph_ff <= ph_in;
         c_ff  <= coef.c;
         f_ff  <= coef.f;
         i_ff  <= coef.i;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sw_ff <= sw_in;
         wz_ff <= wz_in;
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         mx_ff <= mx_in;
         my_ff <= my_in;
         mw_ff <= mw_in;
      end
   end

   assign div_out = div_ff;

endmodule

// ===== design/ppm_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage for X and Y
// against the shared |W|. Depends on ppm_pkg.
module ppm_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  ppm_pkg::div_stage_type div_in,
   output ppm_pkg::div_stage_type div_out
);

   ppm_pkg::div_stage_type st_ff [ppm_pkg::Q_W];
   ppm_pkg::div_stage_type st_in [ppm_pkg::Q_W];

   for (genvar j = 0; j < ppm_pkg::Q_W; j++) begin : g_step
      localparam int K = ppm_pkg::Q_W - 1 - j;

      ppm_pkg::div_stage_type    src;
      logic [ppm_pkg::CMP_W-1:0] dsh, rx, ry;
      logic                      tx, ty;

      if (j == 0) begin : g_first
         assign src = div_in;
      end else begin : g_next
         assign src = st_ff[j-1];
      end

      always_comb begin
         dsh       = ppm_pkg::CMP_W'(src.den) << K;
         rx        = ppm_pkg::CMP_W'(src.rem_x);
         ry        = ppm_pkg::CMP_W'(src.rem_y);
         tx        = rx >= dsh;
         ty        = ry >= dsh;
         st_in[j]  = src;
         if (tx) begin
            st_in[j].rem_x = ppm_pkg::REM_W'(rx - dsh);
         end
         if (ty) begin
            st_in[j].rem_y = ppm_pkg::REM_W'(ry - dsh);
         end
         st_in[j].q_x = {src.q_x[ppm_pkg::Q_W-2:0], tx};
         st_in[j].q_y = {src.q_y[ppm_pkg::Q_W-2:0], ty};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[j].valid <= 1'b0;
         end else if (adv) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign div_out = st_ff[ppm_pkg::Q_W-1];

endmodule
